// ----- src/graph_connectivity_classifier_unit_defines.svh -----
// ----------------------------------------------------------------------------
// graph connectivity classifier assertion macros
// shared concurrent assertion forms, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef GRAPH_CONNECTIVITY_CLASSIFIER_UNIT_DEFINES_SVH
`define GRAPH_CONNECTIVITY_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication
`define GCC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GCC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/gcc_pkg.sv -----
// ----------------------------------------------------------------------------
// gcc_pkg
// types and constants of the graph connectivity classifier
// ----------------------------------------------------------------------------
`default_nettype none

package gcc_pkg;

    localparam int ROW_W  = 64;
    localparam int NODE_W = 7;
    localparam int CONN_W = 2;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [NODE_W-1:0] NODE_COUNT_RESET = 7'd64;

    // register index of node_count
    localparam logic REG_NODE_COUNT = 1'b0;

    localparam logic [CONN_W-1:0] CONN_NONE   = 2'd0;
    localparam logic [CONN_W-1:0] CONN_STRONG = 2'd1;
    localparam logic [CONN_W-1:0] CONN_WEAK   = 2'd2;

    typedef enum logic [1:0] {
        WALK_FWD,
        WALK_BWD,
        WALK_BOTH
    } walk_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS,
        ST_TAIL
    } state_t;

endpackage

`default_nettype wire

// ----- src/graph_connectivity_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// graph connectivity classifier
// stores adjacency rows and classifies the graph as strongly, weakly or not
// connected
// ----------------------------------------------------------------------------
// A row request is taken when start is high and busy is low, one row per
// cycle while loading. The row flagged row_last starts classification and
// busy stays high until done pulses for one cycle with connectivity; the
// result cannot be held off, so it must be captured in that cycle. Rows live
// in a single-port-read memory and every classification cycle reads one row:
// a closure pass reads the rows of the n active nodes in turn, a walk repeats
// passes until one adds no node (at most n passes), and up to three walks
// run (forward, backward, undirected). No clearing pass follows reset.
`default_nettype none
`include "graph_connectivity_classifier_unit_defines.svh"

module graph_connectivity_classifier_unit #(
    parameter int MAX_NODES = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [gcc_pkg::ROW_W-1:0]   row_bits,
    input  wire logic                        row_last,
    output logic                             done,
    output logic [gcc_pkg::CONN_W-1:0]       connectivity,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [gcc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [gcc_pkg::DATA_W-1:0]  pwdata,
    output logic [gcc_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);
    import gcc_pkg::*;

    localparam int AW = $clog2(MAX_NODES);
    localparam logic [NODE_W-1:0] MAX_N = NODE_W'(MAX_NODES);

    // adjacency memory
    logic [ROW_W-1:0] mem [MAX_NODES];
    logic [ROW_W-1:0] rd_data_reg;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;

    state_t           state_reg, state_next;
    walk_mode_t       mode_reg, mode_next;
    logic [NODE_W-1:0] node_count_reg;
    logic [NODE_W-1:0] row_counter_reg, row_counter_next;
    logic [ROW_W-1:0] reached_reg, reached_next;
    logic             changed_reg, changed_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    proc_idx_reg, proc_idx_next;
    logic             proc_valid_reg, proc_valid_next;
    logic             done_reg, done_next;
    logic [CONN_W-1:0] conn_reg, conn_next;

    logic             accept;
    logic             cfg_write;
    logic [NODE_W-1:0] active_n;
    logic [ROW_W-1:0] node_mask;
    logic [ROW_W-1:0] row_m;
    logic [ROW_W-1:0] upd;
    logic             pass_changed;
    logic             walk_full;
    logic             idx_last;

    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign done         = done_reg;
    assign connectivity = conn_reg;
    assign pready       = 1'b1;
    assign cfg_write    = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);
    assign prdata       = (paddr[2] == REG_NODE_COUNT)
                          ? {{(DATA_W-NODE_W){1'b0}}, node_count_reg} : '0;

    // zero means one node, anything above the store depth is clipped
    always_comb
    begin
        if (node_count_reg == '0)
        begin
            active_n = NODE_W'(1);
        end
        else if (node_count_reg > MAX_N)
        begin
            active_n = MAX_N;
        end
        else
        begin
            active_n = node_count_reg;
        end
    end

    always_comb
    begin
        for (int j = 0; j < ROW_W; j++)
        begin
            node_mask[j] = (NODE_W'(j) < active_n);
        end
    end

    assign idx_last = ({{(NODE_W-AW){1'b0}}, idx_reg} == (active_n - NODE_W'(1)));

    // fold the row read last cycle into the reached set
    always_comb
    begin
        row_m = rd_data_reg & node_mask;
        upd   = reached_reg;
        if (proc_valid_reg)
        begin
            if ((mode_reg != WALK_BWD) && reached_reg[proc_idx_reg])
            begin
                upd = upd | row_m;
            end
            if ((mode_reg != WALK_FWD) && ((row_m & reached_reg) != '0))
            begin
                upd[proc_idx_reg] = 1'b1;
            end
        end
    end

    assign pass_changed = changed_reg || (upd != reached_reg);
    assign walk_full    = (upd == node_mask);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && row_last)
                begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (idx_last)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                if (pass_changed)
                begin
                    state_next = ST_PASS;
                end
                else if ((mode_reg == WALK_BOTH) || ((mode_reg == WALK_BWD) && walk_full))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_PASS;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        row_counter_next = row_counter_reg;
        reached_next     = reached_reg;
        changed_next     = changed_reg;
        idx_next         = idx_reg;
        proc_idx_next    = proc_idx_reg;
        proc_valid_next  = 1'b0;
        mode_next        = mode_reg;
        done_next        = 1'b0;
        conn_next        = conn_reg;
        wr_en            = 1'b0;
        wr_addr          = row_counter_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // rows beyond the store are dropped
                    if (row_counter_reg < MAX_N)
                    begin
                        wr_en            = 1'b1;
                        row_counter_next = row_counter_reg + NODE_W'(1);
                    end
                    if (row_last)
                    begin
                        row_counter_next = '0;
                        reached_next     = ROW_W'(1);
                        changed_next     = 1'b0;
                        idx_next         = '0;
                        mode_next        = WALK_FWD;
                    end
                end
            end
            ST_PASS:
            begin
                proc_valid_next = 1'b1;
                proc_idx_next   = idx_reg;
                idx_next        = idx_last ? '0 : idx_reg + AW'(1);
                reached_next    = upd;
                changed_next    = pass_changed;
            end
            ST_TAIL:
            begin
                reached_next = upd;
                changed_next = 1'b0;
                idx_next     = '0;
                if (!pass_changed)
                begin
                    unique case (mode_reg)
                        WALK_FWD:
                        begin
                            mode_next    = walk_full ? WALK_BWD : WALK_BOTH;
                            reached_next = ROW_W'(1);
                        end
                        WALK_BWD:
                        begin
                            if (walk_full)
                            begin
                                done_next = 1'b1;
                                conn_next = CONN_STRONG;
                            end
                            else
                            begin
                                mode_next    = WALK_BOTH;
                                reached_next = ROW_W'(1);
                            end
                        end
                        WALK_BOTH:
                        begin
                            done_next = 1'b1;
                            conn_next = walk_full ? CONN_WEAK : CONN_NONE;
                        end
                        default:
                        begin
                            mode_next = WALK_BOTH;
                        end
                    endcase
                end
            end
            default:
            begin
                row_counter_next = '0;
            end
        endcase
    end

    // last row is written at the edge that enters the pass state, before the first read, so no bypass needed
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= row_bits;
        end
        rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mode_reg        <= WALK_FWD;
            node_count_reg  <= NODE_COUNT_RESET;
            row_counter_reg <= '0;
            reached_reg     <= '0;
            changed_reg     <= 1'b0;
            idx_reg         <= '0;
            proc_valid_reg  <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            row_counter_reg <= row_counter_next;
            reached_reg     <= reached_next;
            changed_reg     <= changed_next;
            idx_reg         <= idx_next;
            proc_valid_reg  <= proc_valid_next;
            done_reg        <= done_next;
            if (cfg_write)
            begin
                node_count_reg <= pwdata[NODE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg <= proc_idx_next;
        conn_reg     <= conn_next;
    end

    `GCC_ASSERT_NOW(a_done_idle, done_reg, state_reg == ST_IDLE,
        "result strobe outside idle")
    `GCC_ASSERT_NEXT(a_last_starts, accept && row_last,
        (state_reg == ST_PASS) && (row_counter_reg == '0) && (reached_reg == ROW_W'(1)),
        "last row did not start classification")
    `GCC_ASSERT_NOW(a_root_reached, busy, reached_reg[0],
        "root node missing from reached set")
    `GCC_ASSERT_NOW(a_reached_in_range, busy, (reached_reg & ~node_mask) == '0,
        "reached set holds inactive node")
    `GCC_ASSERT_NOW(a_proc_after_pass, proc_valid_reg, $past(state_reg) == ST_PASS,
        "row folded without a read issued")

endmodule

`default_nettype wire
